[sv/frame_tile_deduplicator_macros.svh]
// ----------------------------------------------------------------------------
// Frame tile deduplicator assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef FRAME_TILE_DEDUPLICATOR_MACROS_SVH
`define FRAME_TILE_DEDUPLICATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge outside reset
`define FTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included
`define FTD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTD_ASSERT(label, clk, rst_n, prop, msg)
`define FTD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/ftd_pkg.sv]
// ----------------------------------------------------------------------------
// ftd_pkg
// Shared constants, types and register codes of the frame tile deduplicator.
// ----------------------------------------------------------------------------
package ftd_pkg;

  localparam int MAX_TILES_DEF       = 1024;
  localparam int MAX_FRAME_WIDTH_DEF = 1024;
  localparam int TILE_SIDE_DEF       = 16;

  localparam int MAX_FRAME_HEIGHT = 1024;
  localparam int MAX_RESULTS      = 64;

  localparam int PIXEL_W  = 32;
  localparam int IDX_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_W    = 11;
  localparam int TCNT_W   = 7;
  localparam int ROW_W    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPEND,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] store_index;
    logic             is_new;
    logic             overflow;
    logic             last_of_strip;
    logic             last_of_frame;
  } result_t;

endpackage

[sv/ftd_ram.sv]
// ----------------------------------------------------------------------------
// ftd_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ftd_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = ftd_pkg::PIXEL_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/frame_tile_deduplicator.sv]
// ----------------------------------------------------------------------------
// frame_tile_deduplicator
// Buffers one strip of pixel rows, cuts it into square tiles and matches each
// tile against a tile store, appending tiles that are not yet stored.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  in      | input     | in_valid/in_stall | pixel, new_animation
//  out     | output    | out_valid/out_stall | store_index, is_new, overflow,
//          |           |                   | last_of_strip, last_of_frame
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// Flow: a pixel that does not close a producing strip is only written into the
//   strip buffer. A pixel that closes a producing strip starts tile work: per
//   tile, each stored tile is walked word by word through the tile store read
//   port (stopping early on a mismatch); when no candidate is left, a new tile
//   is copied in if the store has room, and the result is held until taken.
//   The tile store has a single read port, so the walk goes one word at a time.
// Reset: synchronous, active low; the stores are not cleared, nothing reads an
//   entry before it is written.
// Stalls: out_stall holds the result register; in_stall stays high until the
//   last tile transaction of the strip has been taken.
// ----------------------------------------------------------------------------
`include "frame_tile_deduplicator_macros.svh"

module frame_tile_deduplicator #(
  parameter int MAX_TILES       = ftd_pkg::MAX_TILES_DEF,
  parameter int MAX_FRAME_WIDTH = ftd_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int TILE_SIDE       = ftd_pkg::TILE_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ftd_pkg::PIXEL_W-1:0]     in_pixel,
  input  logic                            in_new_animation,
  // tile results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ftd_pkg::IDX_W-1:0]       out_store_index,
  output logic                            out_is_new,
  output logic                            out_overflow,
  output logic                            out_last_of_strip,
  output logic                            out_last_of_frame,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TILE_WORDS = TILE_SIDE * TILE_SIDE;
  localparam int SB_DEPTH   = TILE_SIDE * MAX_FRAME_WIDTH;
  localparam int SB_AW      = $clog2(SB_DEPTH);
  localparam int TS_DEPTH   = MAX_TILES * TILE_WORDS;
  localparam int TS_AW      = $clog2(TS_DEPTH);
  localparam int CWI        = $clog2(MAX_FRAME_WIDTH);
  localparam int WEW        = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int YW         = $clog2(TILE_SIDE);
  localparam int RFW        = $clog2(TILE_SIDE + 1);
  localparam int KW         = $clog2(MAX_TILES + 1);
  localparam int SW         = $clog2(ftd_pkg::MAX_FRAME_HEIGHT / TILE_SIDE + 1);
  localparam int DW         = ftd_pkg::DIM_W;
  localparam int TW         = ftd_pkg::TCNT_W;
  localparam int RW         = ftd_pkg::ROW_W;
  localparam int IW         = ftd_pkg::IDX_W;
  localparam int PW         = ftd_pkg::PIXEL_W;
  localparam int ACROSS_LIM = (MAX_FRAME_WIDTH / TILE_SIDE > ftd_pkg::MAX_RESULTS) ?
                              ftd_pkg::MAX_RESULTS : MAX_FRAME_WIDTH / TILE_SIDE;
  localparam logic [YW-1:0] X_LAST = YW'(TILE_SIDE - 1);

  // configuration registers
  logic [DW-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [TW-1:0] ta_r, ta_nxt, td_r, td_nxt;

  // raster position
  logic [CWI-1:0]   col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [YW-1:0]    ris_r, ris_nxt;
  logic [SW-1:0]    strip_r, strip_nxt;
  logic [SB_AW-1:0] rbase_in_r, rbase_in_nxt;
  logic [KW-1:0]    count_r, count_nxt;

  // strip job
  ftd_pkg::state_t  state_r, state_nxt;
  logic [TW-1:0]    n_r, n_nxt, j_r, j_nxt;
  logic [RFW-1:0]   rf_r, rf_nxt;
  logic             ef_r, ef_nxt;
  logic [WEW-1:0]   col_base_r, col_base_nxt;

  // word walk
  logic [KW-1:0]    k_r, k_nxt;
  logic [TS_AW-1:0] sbase_r, sbase_nxt, saddr_r, saddr_nxt;
  logic [YW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [SB_AW-1:0] rbase_r, rbase_nxt;
  logic [WEW-1:0]   cpos_r, cpos_nxt;
  logic             iss_done_r, iss_done_nxt;

  // read-data alignment stage
  logic             pv_r, pv_nxt, ppad_r, ppad_nxt, plast_r, plast_nxt;
  logic [TS_AW-1:0] paddr_r, paddr_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  ftd_pkg::result_t res_r, res_nxt;

  // memory ports
  logic             sb_we;
  logic [SB_AW-1:0] sb_waddr, sb_raddr;
  logic [PW-1:0]    sb_rdata;
  logic             ts_we;
  logic [TS_AW-1:0] ts_waddr;
  logic [PW-1:0]    ts_wdata, ts_rdata;

  logic [WEW-1:0]   eff_w;
  logic [DW-1:0]    eff_h;
  logic [TW-1:0]    eff_n;

  // Effective frame geometry: zero width or height reads as one, oversize saturates
  always_comb begin
    if (fw_r == '0) begin
      eff_w = WEW'(1);
    end else if (32'(fw_r) > 32'(MAX_FRAME_WIDTH)) begin
      eff_w = WEW'(MAX_FRAME_WIDTH);
    end else begin
      eff_w = WEW'(fw_r);
    end
    if (fh_r == '0) begin
      eff_h = DW'(1);
    end else if (32'(fh_r) > 32'(ftd_pkg::MAX_FRAME_HEIGHT)) begin
      eff_h = DW'(ftd_pkg::MAX_FRAME_HEIGHT);
    end else begin
      eff_h = fh_r;
    end
    eff_n = (32'(ta_r) > 32'(ACROSS_LIM)) ? TW'(ACROSS_LIM) : ta_r;
  end

  ftd_ram #(.DEPTH(SB_DEPTH), .AW(SB_AW), .DW(PW)) u_strip_buf (
    .clk   (clk),
    .we    (sb_we),
    .waddr (sb_waddr),
    .wdata (in_pixel),
    .raddr (sb_raddr),
    .rdata (sb_rdata)
  );

  ftd_ram #(.DEPTH(TS_DEPTH), .AW(TS_AW), .DW(PW)) u_tile_store (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .raddr (saddr_r),
    .rdata (ts_rdata)
  );

  // Strip word of the walk: row base plus absolute column
  assign sb_raddr = rbase_r + SB_AW'(cpos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftd_pkg::ST_IDLE;
      fw_r        <= DW'(1);
      fh_r        <= DW'(1);
      ta_r        <= '0;
      td_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      ris_r       <= '0;
      strip_r     <= '0;
      rbase_in_r  <= '0;
      count_r     <= '0;
      pv_r        <= 1'b0;
      iss_done_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      ta_r        <= ta_nxt;
      td_r        <= td_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ris_r       <= ris_nxt;
      strip_r     <= strip_nxt;
      rbase_in_r  <= rbase_in_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      iss_done_r  <= iss_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    rf_r       <= rf_nxt;
    ef_r       <= ef_nxt;
    col_base_r <= col_base_nxt;
    k_r        <= k_nxt;
    sbase_r    <= sbase_nxt;
    saddr_r    <= saddr_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    rbase_r    <= rbase_nxt;
    cpos_r     <= cpos_nxt;
    ppad_r     <= ppad_nxt;
    plast_r    <= plast_nxt;
    paddr_r    <= paddr_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    logic [WEW-1:0]   col_inc;
    logic [DW-1:0]    r1;
    logic             endf;
    logic             ends;
    logic             mismatch;
    logic             restart;
    logic             issue_ok;
    logic             tile_last;
    logic [TS_AW-1:0] restart_base;
    logic [WEW-1:0]   restart_col;

    state_nxt     = state_r;
    fw_nxt        = fw_r;
    fh_nxt        = fh_r;
    ta_nxt        = ta_r;
    td_nxt        = td_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ris_nxt       = ris_r;
    strip_nxt     = strip_r;
    rbase_in_nxt  = rbase_in_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    rf_nxt        = rf_r;
    ef_nxt        = ef_r;
    col_base_nxt  = col_base_r;
    k_nxt         = k_r;
    sbase_nxt     = sbase_r;
    saddr_nxt     = saddr_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rbase_nxt     = rbase_r;
    cpos_nxt      = cpos_r;
    iss_done_nxt  = iss_done_r;
    pv_nxt        = 1'b0;
    ppad_nxt      = ppad_r;
    plast_nxt     = plast_r;
    paddr_nxt     = paddr_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    sb_we    = 1'b0;
    sb_waddr = rbase_in_r + SB_AW'(col_r);
    ts_we    = 1'b0;
    ts_waddr = paddr_r;
    ts_wdata = ppad_r ? '0 : sb_rdata;

    col_inc      = WEW'(col_r) + WEW'(1);
    r1           = DW'(row_r) + DW'(1);
    endf         = r1 >= eff_h;
    ends         = (ris_r == X_LAST) || endf;
    mismatch     = pv_r && (ts_rdata != (ppad_r ? '0 : sb_rdata));
    restart      = 1'b0;
    issue_ok     = 1'b0;
    tile_last    = (j_r + TW'(1)) == n_r;
    restart_base = sbase_r;
    restart_col  = col_base_r;

    in_stall  = (state_r != ftd_pkg::ST_IDLE);
    cfg_ready = (state_r == ftd_pkg::ST_IDLE);

    unique case (state_r)
      ftd_pkg::ST_IDLE: begin
        if (in_valid) begin
          // empty the store, then take the pixel into the strip
          if (in_new_animation) begin
            count_nxt = '0;
          end
          sb_we = 1'b1;
          if (col_inc < eff_w) begin
            col_nxt = CWI'(col_inc);
          end else begin
            col_nxt = '0;
            row_nxt = endf ? '0 : RW'(r1);
            if (ends) begin
              ris_nxt      = '0;
              rbase_in_nxt = '0;
              strip_nxt    = endf ? '0 : strip_r + SW'(1);
              if ((32'(strip_r) < 32'(td_r)) && (eff_n != '0)) begin
                // strip closes with results: start on tile column zero
                n_nxt        = eff_n;
                j_nxt        = '0;
                rf_nxt       = RFW'(ris_r) + RFW'(1);
                ef_nxt       = endf;
                col_base_nxt = '0;
                k_nxt        = '0;
                sbase_nxt    = '0;
                restart      = 1'b1;
                restart_base = '0;
                restart_col  = '0;
                state_nxt    = ftd_pkg::ST_CMP;
              end
            end else begin
              ris_nxt      = ris_r + YW'(1);
              rbase_in_nxt = rbase_in_r + SB_AW'(MAX_FRAME_WIDTH);
            end
          end
        end
      end

      ftd_pkg::ST_CMP: begin
        if (k_r == count_r) begin
          // every stored tile differs
          if (count_r == KW'(MAX_TILES)) begin
            res_nxt.store_index = '0;
            res_nxt.is_new     = 1'b0;
            res_nxt.overflow   = 1'b1;
            res_nxt.last_of_strip = tile_last;
            res_nxt.last_of_frame = tile_last && ef_r;
            out_valid_nxt      = 1'b1;
            state_nxt          = ftd_pkg::ST_RESULT;
          end else begin
            restart   = 1'b1;
            state_nxt = ftd_pkg::ST_APPEND;
          end
        end else if (mismatch) begin
          // drop this candidate, advance to the next stored tile
          k_nxt        = k_r + KW'(1);
          sbase_nxt    = sbase_r + TS_AW'(TILE_WORDS);
          restart      = 1'b1;
          restart_base = sbase_r + TS_AW'(TILE_WORDS);
        end else if (pv_r && plast_r) begin
          res_nxt.store_index   = IW'(k_r);
          res_nxt.is_new        = 1'b0;
          res_nxt.overflow      = 1'b0;
          res_nxt.last_of_strip = tile_last;
          res_nxt.last_of_frame = tile_last && ef_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ftd_pkg::ST_RESULT;
        end else begin
          issue_ok = 1'b1;
        end
      end

      ftd_pkg::ST_APPEND: begin
        // copy the tile into the entry at the current fill count
        issue_ok = 1'b1;
        if (pv_r) begin
          ts_we = 1'b1;
          if (plast_r) begin
            count_nxt             = count_r + KW'(1);
            res_nxt.store_index   = IW'(count_r);
            res_nxt.is_new        = 1'b1;
            res_nxt.overflow      = 1'b0;
            res_nxt.last_of_strip = tile_last;
            res_nxt.last_of_frame = tile_last && ef_r;
            out_valid_nxt         = 1'b1;
            state_nxt             = ftd_pkg::ST_RESULT;
          end
        end
      end

      ftd_pkg::ST_RESULT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (tile_last) begin
            state_nxt = ftd_pkg::ST_IDLE;
          end else begin
            j_nxt        = j_r + TW'(1);
            col_base_nxt = col_base_r + WEW'(TILE_SIDE);
            k_nxt        = '0;
            sbase_nxt    = '0;
            restart      = 1'b1;
            restart_base = '0;
            restart_col  = col_base_r + WEW'(TILE_SIDE);
            state_nxt    = ftd_pkg::ST_CMP;
          end
        end
      end

      default: begin
        state_nxt = ftd_pkg::ST_IDLE;
      end
    endcase

    // Issue one tile word: pad rows below the strip and columns past the frame
    if (issue_ok && !iss_done_r) begin
      pv_nxt    = 1'b1;
      ppad_nxt  = (RFW'(y_r) >= rf_r) || (cpos_r >= eff_w);
      plast_nxt = (x_r == X_LAST) && (y_r == X_LAST);
      paddr_nxt = saddr_r;
      saddr_nxt = saddr_r + TS_AW'(1);
      if (x_r == X_LAST) begin
        x_nxt     = '0;
        y_nxt     = y_r + YW'(1);
        rbase_nxt = rbase_r + SB_AW'(MAX_FRAME_WIDTH);
        cpos_nxt  = col_base_r;
      end else begin
        x_nxt    = x_r + YW'(1);
        cpos_nxt = cpos_r + WEW'(1);
      end
      if ((x_r == X_LAST) && (y_r == X_LAST)) begin
        iss_done_nxt = 1'b1;
      end
    end

    if (restart) begin
      x_nxt        = '0;
      y_nxt        = '0;
      rbase_nxt    = '0;
      cpos_nxt     = restart_col;
      saddr_nxt    = restart_base;
      iss_done_nxt = 1'b0;
    end

    // Configuration: a geometry write restarts the frame at its origin
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ftd_pkg::CFG_FRAME_WIDTH: begin
          fw_nxt = cfg_wdata;
        end
        ftd_pkg::CFG_FRAME_HEIGHT: begin
          fh_nxt = cfg_wdata;
        end
        ftd_pkg::CFG_TILES_ACROSS: begin
          ta_nxt = TW'(cfg_wdata);
        end
        ftd_pkg::CFG_TILES_DOWN: begin
          td_nxt = TW'(cfg_wdata);
        end
        default: begin
        end
      endcase
      if (cfg_index == ftd_pkg::CFG_FRAME_WIDTH || cfg_index == ftd_pkg::CFG_FRAME_HEIGHT) begin
        col_nxt      = '0;
        row_nxt      = '0;
        ris_nxt      = '0;
        strip_nxt    = '0;
        rbase_in_nxt = '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_store_index   = res_r.store_index;
  assign out_is_new        = res_r.is_new;
  assign out_overflow      = res_r.overflow;
  assign out_last_of_strip = res_r.last_of_strip;
  assign out_last_of_frame = res_r.last_of_frame;

  // A result transaction is only ever offered while input is held off
  `FTD_ASSERT(a_result_blocks_input, clk, rst_n, out_valid |-> in_stall, "result offered while accepting pixels")
  // The fill count never passes the store depth; reset brings it to zero
  `FTD_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || count_r <= KW'(MAX_TILES), "tile count beyond store depth")
  // A new tile result comes with exactly one more stored tile
  `FTD_ASSERT(a_new_bumps_count, clk, rst_n, $rose(out_valid) && out_is_new |-> count_r == KW'($past(count_r) + KW'(1)), "appended tile without count step")
  // Overflow is reported only on a full store
  `FTD_ASSERT(a_overflow_full, clk, rst_n, out_valid && out_overflow |-> count_r == KW'(MAX_TILES), "overflow on a store with room")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Frame tile deduplicator testbench
// Drives raster pixels and register writes into the deduplicator, predicts
// every tile transaction from a behavioural copy of the strip buffer and the
// tile store, and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE        = ftd_pkg::TILE_SIDE_DEF;
  localparam int TILE_WORDS  = SIDE * SIDE;
  localparam int LINE_MAX    = ftd_pkg::MAX_FRAME_WIDTH_DEF;
  localparam int STORE_DEPTH = ftd_pkg::MAX_TILES_DEF;
  localparam int RANDOM_ITEMS = 317;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ftd_pkg::PIXEL_W-1:0]    in_pixel = '0;
  logic                           in_new_animation = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ftd_pkg::IDX_W-1:0]      out_store_index;
  logic                           out_is_new;
  logic                           out_overflow;
  logic                           out_last_of_strip;
  logic                           out_last_of_frame;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ftd_pkg::CFG_IDX_W-1:0]  cfg_index = ftd_pkg::CFG_FRAME_WIDTH;
  logic [ftd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_tile_deduplicator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel(in_pixel), .in_new_animation(in_new_animation),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_store_index(out_store_index), .out_is_new(out_is_new),
    .out_overflow(out_overflow), .out_last_of_strip(out_last_of_strip),
    .out_last_of_frame(out_last_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow state of the block: strip rows, tile store, raster position, registers
  logic [31:0]      strip_rows [0:SIDE*LINE_MAX-1];
  logic [31:0]      tile_mem   [0:STORE_DEPTH*TILE_WORDS-1];
  logic [31:0]      cut_tile   [0:TILE_WORDS-1];
  int unsigned      tiles_held;
  int unsigned      raster_col, raster_row;
  logic [ftd_pkg::DIM_W-1:0]  reg_width, reg_height;
  logic [ftd_pkg::TCNT_W-1:0] reg_across, reg_down;

  ftd_pkg::result_t expected_tiles [$];
  int      mismatches;
  int      orphans;
  bit      quiet;          // suppress input gaps and new result stalls
  int      stall_left;

  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Cut tile j of the current strip, zero padding outside the frame
  function automatic void cut_strip_tile(int unsigned j, int unsigned rows, int unsigned w);
    int unsigned c;
    for (int i = 0; i < TILE_WORDS; i++) cut_tile[i] = '0;
    for (int y = 0; y < SIDE && y < rows; y++)
      for (int x = 0; x < SIDE; x++) begin
        c = j * SIDE + x;
        if (c < w) cut_tile[y*SIDE + x] = strip_rows[y*LINE_MAX + c];
      end
  endfunction

  function automatic ftd_pkg::result_t match_or_append();
    ftd_pkg::result_t res;
    bit      same;
    res = '0;
    for (int unsigned k = 0; k < tiles_held; k++) begin
      same = 1'b1;
      for (int i = 0; i < TILE_WORDS && same; i++)
        if (tile_mem[k*TILE_WORDS + i] != cut_tile[i]) same = 1'b0;
      if (same) begin
        res.store_index = k[ftd_pkg::IDX_W-1:0];
        return res;
      end
    end
    if (tiles_held >= STORE_DEPTH) begin
      res.overflow = 1'b1;
      return res;
    end
    for (int i = 0; i < TILE_WORDS; i++) tile_mem[tiles_held*TILE_WORDS + i] = cut_tile[i];
    res.store_index = tiles_held[ftd_pkg::IDX_W-1:0];
    res.is_new = 1'b1;
    tiles_held++;
    return res;
  endfunction

  // Advance the raster by one pixel and queue the tiles that it releases
  function automatic void predict_tiles(logic [31:0] pix, logic restart);
    int unsigned w, h, col, r, strip, rows, n;
    bit          frame_done;
    ftd_pkg::result_t res;
    w = (reg_width == 0) ? 1 : (reg_width > LINE_MAX) ? LINE_MAX : reg_width;
    h = (reg_height == 0) ? 1 :
        (reg_height > ftd_pkg::MAX_FRAME_HEIGHT) ? ftd_pkg::MAX_FRAME_HEIGHT : reg_height;
    if (restart) tiles_held = 0;
    col = (raster_col >= w) ? 0 : raster_col;
    r   = (raster_row >= h) ? 0 : raster_row;
    strip_rows[(r % SIDE)*LINE_MAX + col] = pix;
    col++;
    if (col < w) begin
      raster_col = col;
      raster_row = r;
      return;
    end
    raster_col = 0;
    r++;
    frame_done = (r >= h);
    raster_row = frame_done ? 0 : r;
    if ((r % SIDE) != 0 && !frame_done) return;
    strip = (r - 1) / SIDE;
    rows  = r - strip * SIDE;
    if (strip >= reg_down) return;
    n = (reg_across > ftd_pkg::MAX_RESULTS) ? ftd_pkg::MAX_RESULTS : reg_across;
    if (n > LINE_MAX / SIDE) n = LINE_MAX / SIDE;
    for (int unsigned j = 0; j < n; j++) begin
      cut_strip_tile(j, rows, w);
      res = match_or_append();
      res.last_of_strip = (j + 1 == n);
      res.last_of_frame = frame_done && (j + 1 == n);
      expected_tiles = {expected_tiles, res};
    end
  endfunction

  // Result side: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    ftd_pkg::result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_store_index, out_is_new, out_overflow, out_last_of_strip,
              out_last_of_frame};
      if (expected_tiles.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10)
          $display("%0t unexpected tile transaction %p", $realtime, got);
      end else begin
        want = expected_tiles.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches + orphans <= 10)
            $display("%0t tile mismatch: expected %p, got %p", $realtime, want, got);
        end
      end
    end
    // Stall the result side at random, mostly briefly
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Send one pixel transaction, then idle for a random gap
  task automatic send_pixel(logic [31:0] pix, logic restart);
    int unsigned gap;
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_new_animation <= restart;
    do @(posedge clk); while (in_stall);
    predict_tiles(pix, restart);
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, then hold until every expected tile has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tiles.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_reg(logic [ftd_pkg::CFG_IDX_W-1:0] idx,
                           logic [ftd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ftd_pkg::CFG_FRAME_WIDTH: begin
        reg_width = val;
        raster_col = 0;
        raster_row = 0;
      end
      ftd_pkg::CFG_FRAME_HEIGHT: begin
        reg_height = val;
        raster_col = 0;
        raster_row = 0;
      end
      ftd_pkg::CFG_TILES_ACROSS: reg_across = val[ftd_pkg::TCNT_W-1:0];
      ftd_pkg::CFG_TILES_DOWN:   reg_down = val[ftd_pkg::TCNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int across, int down);
    write_reg(ftd_pkg::CFG_FRAME_WIDTH, w[ftd_pkg::CFG_DATA_W-1:0]);
    write_reg(ftd_pkg::CFG_FRAME_HEIGHT, h[ftd_pkg::CFG_DATA_W-1:0]);
    write_reg(ftd_pkg::CFG_TILES_ACROSS, across[ftd_pkg::CFG_DATA_W-1:0]);
    write_reg(ftd_pkg::CFG_TILES_DOWN, down[ftd_pkg::CFG_DATA_W-1:0]);
  endtask

  // Directed: extremes of pixel values, zero sizes, full result burst, restart
  task automatic test_directed();
    // Zero width and height act as one pixel; 127 tiles across saturates to 64
    set_frame(0, 0, 2047, 127);
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hA5A5_5A5A, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    drain();
    // No producing strips: nothing comes out
    set_frame(3, 2, 1, 0);
    for (int i = 0; i < 6; i++) send_pixel($urandom, 1'b0);
    drain();
    // Short frame with two padded tiles; repeat it to get matches
    set_frame(5, 2, 2, 1);
    for (int k = 0; k < 2; k++)
      for (int i = 0; i < 10; i++) send_pixel(i * 32'h0101_0101, 1'b0);
    drain();
  endtask

  // Width change mid-strip drops the strip collected so far
  task automatic test_restart_on_resize();
    set_frame(6, 4, 1, 1);
    for (int i = 0; i < 9; i++) send_pixel($urandom, 1'b0);
    drain();
    write_reg(ftd_pkg::CFG_FRAME_WIDTH, 11'd4);
    for (int i = 0; i < 5; i++) send_pixel($urandom, 1'b0);
    drain();
    write_reg(ftd_pkg::CFG_FRAME_HEIGHT, 11'd2);
    for (int i = 0; i < 8; i++) send_pixel($urandom_range(0, 1), 1'b0);
    drain();
  endtask

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return $urandom_range(0, 3);
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random frames, mostly whole, some cut short; low-entropy pixels give matches
  task automatic test_random_frames();
    int sent, w, h, n, total;
    bit paused;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 20);
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 18);
      set_frame(w, h, $urandom_range(0, 5), $urandom_range(0, 2));
      total = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) : total;
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      paused = 1'b0;
      for (int i = 0; i < n; i++) begin
        // Hold off once in a while until all tiles have come back
        if (!paused && i == n / 2 && $urandom_range(0, 1) == 1) begin
          paused = 1'b1;
          in_valid <= 1'b0;
          do @(posedge clk); while (expected_tiles.size() != 0);
        end
        send_pixel(pick_pixel(), (i == 0 && $urandom_range(0, 2) == 0) ||
                                 $urandom_range(0, 63) == 0);
      end
      sent += n;
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    tiles_held = 0;
    raster_col = 0;
    raster_row = 0;
    reg_width  = 1;
    reg_height = 1;
    reg_across = 0;
    reg_down   = 0;
    mismatches = 0;
    orphans    = 0;
    quiet      = 1'b0;
    stall_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_restart_on_resize();
    test_random_frames();
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && orphans == 0 && expected_tiles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, with every tile walking a
  // crowded store under the longest stalls
  initial begin
    repeat (40) #1_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
